FILE: src/iipv_pkg.sv
// Package for the index image parse/validate block.
// Holds types, codes and limits used across the modules, and the CRC-32 byte step.
`timescale 1ns / 1ps
package iipv_pkg;

  localparam int unsigned PosW       = 21;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 21;
  localparam int unsigned DefSpineBytes = 2;
  localparam int unsigned DefQueueDepth = 4;

  localparam logic [20:0] RstMaxImage = 21'd524288;
  localparam logic [15:0] RstMaxBooks = 16'd64;
  localparam logic [15:0] RstMaxChaps = 16'd4096;
  localparam logic [15:0] RstMaxPath  = 16'd1024;
  localparam logic [15:0] RstMaxTitle = 16'd4096;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Magic "A14EPC02", first byte first.
  localparam logic [7:0] Magic [8] = '{8'h41, 8'h31, 8'h34, 8'h45,
                                        8'h50, 8'h43, 8'h30, 8'h32};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxImage = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxBooks = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxChaps = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxPath  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxTitle = 3'd4;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_PLEN, PH_CRC, PH_BCOUNT, PH_PATH_LEN, PH_PATH_CH,
    PH_TITLE_LEN, PH_TITLE_CH, PH_SIZE, PH_MTIME, PH_TOC, PH_RESUME,
    PH_SECTION, PH_PAGE, PH_CCOUNT, PH_CT_LEN, PH_CT_CH, PH_SPINE,
    PH_DONE, PH_HALT
  } phase_e;

  typedef enum logic [3:0] {
    K_NONE, K_HEADER, K_PATH_CH, K_TITLE_CH, K_CT_CH, K_BCOUNT, K_SIZE,
    K_MTIME, K_TOC, K_RESUME, K_SECTION, K_PAGE, K_CCOUNT, K_SPINE
  } kind_e;

  typedef enum logic [3:0] {
    E_NONE, E_LENGTH, E_MAGIC, E_PSIZE, E_CRC, E_BOOKS, E_STRING,
    E_CHAPS, E_TRUNC, E_TRAIL
  } err_e;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic            crc_en;
    logic            len_bad;
    logic [PosW-1:0] len_m16;
  } item_t;

  typedef struct packed {
    logic [15:0] max_books;
    logic [15:0] max_chaps;
    logic [15:0] max_path;
    logic [15:0] max_title;
  } cfg_t;

  // Reflected CRC-32 over one byte, bitwise.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  // Byte count of the numeric field parsed in a phase.
  function automatic logic [3:0] field_width(input phase_e ph, input logic [3:0] spine);
    logic [3:0] w;
    case (ph)
      PH_PLEN, PH_CRC:    w = 4'd4;
      PH_SIZE, PH_MTIME:  w = 4'd8;
      PH_TOC, PH_RESUME:  w = 4'd1;
      PH_SPINE:           w = spine;
      default:            w = 4'd2;
    endcase
    return w;
  endfunction

endpackage

FILE: src/iipv_front.sv
// Front end: accepts image bytes, tracks byte position and classifies each beat.
// Depends on iipv_pkg.
`timescale 1ns / 1ps
module iipv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  output logic                     in_stall_o,
  input  logic [20:0]              max_image_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output iipv_pkg::item_t          item_o
);

  logic [iipv_pkg::PosW-1:0] pos_q, pos_d;
  logic [iipv_pkg::PosW:0]   len;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the beat from its position in the image.
  always_comb begin
    len             = {1'b0, pos_q} + {{iipv_pkg::PosW{1'b0}}, 1'b1};
    item_o.data     = data_byte_i;
    item_o.last     = last_byte_i;
    item_o.crc_en   = pos_q >= iipv_pkg::PosW'(16);
    item_o.len_bad  = (len < (iipv_pkg::PosW+1)'(16)) || (len > {1'b0, max_image_i});
    item_o.len_m16  = pos_q - iipv_pkg::PosW'(15);
  end

  // Position counter, saturating, cleared after the last beat.
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q != iipv_pkg::PosMax) begin
        pos_d = pos_q + iipv_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: src/iipv_queue.sv
// Short queue of classified beats between the front and the back.
// Depends on iipv_pkg.
`timescale 1ns / 1ps
module iipv_queue #(
  parameter int unsigned DEPTH = iipv_pkg::DefQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iipv_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output iipv_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  iipv_pkg::item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(DEPTH))
    else $error("queue fill count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

endmodule

FILE: src/iipv_back.sv
// Back end: CRC, record walk, error latching and the registered result beat.
// Depends on iipv_pkg.
`timescale 1ns / 1ps
module iipv_back #(
  parameter int unsigned SPINE_INDEX_BYTES = iipv_pkg::DefSpineBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iipv_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  iipv_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [3:0]      field_kind_o,
  output logic [63:0]     field_value_o,
  output logic [15:0]     book_number_o,
  output logic [15:0]     chapter_number_o,
  output logic            verdict_valid_o,
  output logic            image_ok_o,
  output logic [3:0]      error_code_o
);

  localparam logic [3:0] SpineW = 4'(SPINE_INDEX_BYTES);

  iipv_pkg::phase_e phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d, cnt_n, fw;
  logic [63:0] acc_q, acc_d, acc_n;
  logic [31:0] crc_q, crc_d;
  logic [31:0] eplen_q, eplen_d, ecrc_q, ecrc_d;
  logic [15:0] books_q, books_d, book_q, book_d;
  logic [15:0] chaps_q, chaps_d, chap_q, chap_d;
  logic [15:0] str_q, str_d;
  iipv_pkg::err_e err_q, err_d, fail_code, code;
  logic        fail_req, end_book;
  iipv_pkg::kind_e kind;
  logic [63:0] val;

  logic        out_valid_q;
  logic [3:0]  kind_q;
  logic [63:0] val_q;
  logic [15:0] obook_q, ochap_q;
  logic        verdict_q, ok_q;
  logic [3:0]  code_q;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Per-beat parse step.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    eplen_d   = eplen_q;
    ecrc_d    = ecrc_q;
    books_d   = books_q;
    book_d    = book_q;
    chaps_d   = chaps_q;
    chap_d    = chap_q;
    str_d     = str_q;
    err_d     = err_q;
    fail_req  = 1'b0;
    fail_code = iipv_pkg::E_NONE;
    end_book  = 1'b0;
    kind      = iipv_pkg::K_NONE;
    val       = '0;
    code      = iipv_pkg::E_NONE;
    cnt_n     = cnt_q + 4'd1;
    fw        = iipv_pkg::field_width(phase_q, SpineW);
    acc_n     = acc_q;
    if (cnt_q < 4'd8) begin
      acc_n = acc_q | ({56'd0, item_i.data} << {cnt_q[2:0], 3'b000});
    end
    crc_d = item_i.crc_en ? iipv_pkg::crc_byte(crc_q, item_i.data) : crc_q;

    case (phase_q)
      iipv_pkg::PH_MAGIC: begin
        if (item_i.data != iipv_pkg::Magic[cnt_q[2:0]]) begin
          fail_req  = 1'b1;
          fail_code = iipv_pkg::E_MAGIC;
        end else if (cnt_q == 4'd7) begin
          cnt_d   = '0;
          acc_d   = '0;
          phase_d = iipv_pkg::PH_PLEN;
        end else begin
          cnt_d = cnt_n;
        end
      end
      iipv_pkg::PH_PATH_CH, iipv_pkg::PH_TITLE_CH, iipv_pkg::PH_CT_CH: begin
        kind  = (phase_q == iipv_pkg::PH_PATH_CH)  ? iipv_pkg::K_PATH_CH :
                (phase_q == iipv_pkg::PH_TITLE_CH) ? iipv_pkg::K_TITLE_CH :
                                                     iipv_pkg::K_CT_CH;
        val   = {56'd0, item_i.data};
        str_d = str_q - 16'd1;
        if (str_q == 16'd1) begin
          phase_d = (phase_q == iipv_pkg::PH_PATH_CH)  ? iipv_pkg::PH_TITLE_LEN :
                    (phase_q == iipv_pkg::PH_TITLE_CH) ? iipv_pkg::PH_SIZE :
                                                         iipv_pkg::PH_SPINE;
        end
      end
      iipv_pkg::PH_DONE: begin
        fail_req  = 1'b1;
        fail_code = iipv_pkg::E_TRAIL;
      end
      iipv_pkg::PH_HALT: begin
      end
      default: begin
        if (cnt_n >= fw) begin
          cnt_d = '0;
          acc_d = '0;
          case (phase_q)
            iipv_pkg::PH_PLEN: begin
              eplen_d = acc_n[31:0];
              phase_d = iipv_pkg::PH_CRC;
            end
            iipv_pkg::PH_CRC: begin
              ecrc_d  = acc_n[31:0];
              kind    = iipv_pkg::K_HEADER;
              val     = {acc_n[31:0], eplen_q};
              phase_d = iipv_pkg::PH_BCOUNT;
            end
            iipv_pkg::PH_BCOUNT: begin
              if (acc_n > {48'd0, cfg_i.max_books}) begin
                fail_req  = 1'b1;
                fail_code = iipv_pkg::E_BOOKS;
              end else begin
                kind    = iipv_pkg::K_BCOUNT;
                val     = acc_n;
                books_d = acc_n[15:0];
                book_d  = '0;
                if (acc_n == '0) begin
                  phase_d = iipv_pkg::PH_DONE;
                end else begin
                  chap_d  = '0;
                  phase_d = iipv_pkg::PH_PATH_LEN;
                end
              end
            end
            iipv_pkg::PH_PATH_LEN, iipv_pkg::PH_TITLE_LEN, iipv_pkg::PH_CT_LEN: begin
              if (acc_n > {48'd0, (phase_q == iipv_pkg::PH_PATH_LEN) ?
                                  cfg_i.max_path : cfg_i.max_title}) begin
                fail_req  = 1'b1;
                fail_code = iipv_pkg::E_STRING;
              end else begin
                str_d = acc_n[15:0];
                case (phase_q)
                  iipv_pkg::PH_PATH_LEN: phase_d = (acc_n != '0) ?
                      iipv_pkg::PH_PATH_CH : iipv_pkg::PH_TITLE_LEN;
                  iipv_pkg::PH_TITLE_LEN: phase_d = (acc_n != '0) ?
                      iipv_pkg::PH_TITLE_CH : iipv_pkg::PH_SIZE;
                  default: phase_d = (acc_n != '0) ?
                      iipv_pkg::PH_CT_CH : iipv_pkg::PH_SPINE;
                endcase
              end
            end
            iipv_pkg::PH_SIZE: begin
              kind = iipv_pkg::K_SIZE; val = acc_n; phase_d = iipv_pkg::PH_MTIME;
            end
            iipv_pkg::PH_MTIME: begin
              kind = iipv_pkg::K_MTIME; val = acc_n; phase_d = iipv_pkg::PH_TOC;
            end
            iipv_pkg::PH_TOC: begin
              kind = iipv_pkg::K_TOC; val = acc_n; phase_d = iipv_pkg::PH_RESUME;
            end
            iipv_pkg::PH_RESUME: begin
              kind = iipv_pkg::K_RESUME; val = acc_n; phase_d = iipv_pkg::PH_SECTION;
            end
            iipv_pkg::PH_SECTION: begin
              kind = iipv_pkg::K_SECTION; val = acc_n; phase_d = iipv_pkg::PH_PAGE;
            end
            iipv_pkg::PH_PAGE: begin
              kind = iipv_pkg::K_PAGE; val = acc_n; phase_d = iipv_pkg::PH_CCOUNT;
            end
            iipv_pkg::PH_CCOUNT: begin
              if (acc_n > {48'd0, cfg_i.max_chaps}) begin
                fail_req  = 1'b1;
                fail_code = iipv_pkg::E_CHAPS;
              end else begin
                kind    = iipv_pkg::K_CCOUNT;
                val     = acc_n;
                chaps_d = acc_n[15:0];
                chap_d  = '0;
                if (acc_n == '0) begin
                  end_book = 1'b1;
                end else begin
                  phase_d = iipv_pkg::PH_CT_LEN;
                end
              end
            end
            iipv_pkg::PH_SPINE: begin
              kind    = iipv_pkg::K_SPINE;
              val     = acc_n;
              chaps_d = chaps_q - 16'd1;
              chap_d  = chap_q + 16'd1;
              if (chaps_q == 16'd1) begin
                end_book = 1'b1;
              end else begin
                phase_d = iipv_pkg::PH_CT_LEN;
              end
            end
            default: begin
            end
          endcase
        end else begin
          cnt_d = cnt_n;
          acc_d = acc_n;
        end
      end
    endcase

    // Close a book and open the next one if any remain.
    if (end_book) begin
      books_d = books_q - 16'd1;
      book_d  = book_q + 16'd1;
      if (books_q == 16'd1) begin
        phase_d = iipv_pkg::PH_DONE;
      end else begin
        chap_d  = '0;
        phase_d = iipv_pkg::PH_PATH_LEN;
      end
    end

    // A failed check keeps the first error and halts the walk.
    if (fail_req) begin
      if (err_q == iipv_pkg::E_NONE) begin
        err_d = fail_code;
      end
      phase_d = iipv_pkg::PH_HALT;
    end

    // Verdict on the last beat, in priority order.
    if (item_i.last) begin
      if (item_i.len_bad) begin
        code = iipv_pkg::E_LENGTH;
      end else if (err_d == iipv_pkg::E_MAGIC) begin
        code = iipv_pkg::E_MAGIC;
      end else if (eplen_d != {11'd0, item_i.len_m16}) begin
        code = iipv_pkg::E_PSIZE;
      end else if ((crc_d ^ iipv_pkg::CrcInit) != ecrc_d) begin
        code = iipv_pkg::E_CRC;
      end else if (err_d != iipv_pkg::E_NONE) begin
        code = err_d;
      end else if (phase_d != iipv_pkg::PH_DONE) begin
        code = iipv_pkg::E_TRUNC;
      end
    end
  end

  // Parse state; it returns to reset after each image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= iipv_pkg::PH_MAGIC;
      cnt_q   <= '0;
      acc_q   <= '0;
      crc_q   <= iipv_pkg::CrcInit;
      eplen_q <= '0;
      ecrc_q  <= '0;
      books_q <= '0;
      book_q  <= '0;
      chaps_q <= '0;
      chap_q  <= '0;
      str_q   <= '0;
      err_q   <= iipv_pkg::E_NONE;
    end else if (pop_o) begin
      if (item_i.last) begin
        phase_q <= iipv_pkg::PH_MAGIC;
        cnt_q   <= '0;
        acc_q   <= '0;
        crc_q   <= iipv_pkg::CrcInit;
        eplen_q <= '0;
        ecrc_q  <= '0;
        books_q <= '0;
        book_q  <= '0;
        chaps_q <= '0;
        chap_q  <= '0;
        str_q   <= '0;
        err_q   <= iipv_pkg::E_NONE;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        crc_q   <= crc_d;
        eplen_q <= eplen_d;
        ecrc_q  <= ecrc_d;
        books_q <= books_d;
        book_q  <= book_d;
        chaps_q <= chaps_d;
        chap_q  <= chap_d;
        str_q   <= str_d;
        err_q   <= err_d;
      end
    end
  end

  // Output register: holds the result beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q    <= kind;
      val_q     <= val;
      obook_q   <= book_q;
      ochap_q   <= chap_q;
      verdict_q <= item_i.last;
      ok_q      <= item_i.last && (code == iipv_pkg::E_NONE);
      code_q    <= code;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign field_kind_o     = kind_q;
  assign field_value_o    = val_q;
  assign book_number_o    = obook_q;
  assign chapter_number_o = ochap_q;
  assign verdict_valid_o  = verdict_q;
  assign image_ok_o       = ok_q;
  assign error_code_o     = code_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop_o && item_i.last |=> phase_q == iipv_pkg::PH_MAGIC && err_q == iipv_pkg::E_NONE)
    else $error("state not cleared after last beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !verdict_valid_o |-> !image_ok_o && error_code_o == iipv_pkg::E_NONE)
    else $error("verdict fields set on a non-final beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && verdict_valid_o |-> image_ok_o == (error_code_o == iipv_pkg::E_NONE))
    else $error("image_ok disagrees with error code");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      phase_q == iipv_pkg::PH_HALT |-> err_q != iipv_pkg::E_NONE)
    else $error("halted without a latched error");

endmodule

FILE: src/index_image_parse_validate_unit.sv
// Top level of the index image parse/validate block.
// Each accepted byte's result beat passes through the queue and then the output register.
// Throughput: one byte per cycle while in_stall_o is low; the per-byte CRC and record step is combinational.
// A QUEUE_DEPTH-entry queue (4 by default) parts the front from the back; an output register holds results.
// Reset (rst_ni low, asynchronous) clears all parse state and loads default limits.
// Depends on iipv_pkg, iipv_front, iipv_queue and iipv_back.
`timescale 1ns / 1ps
module index_image_parse_validate_unit #(
  parameter int unsigned SPINE_INDEX_BYTES = iipv_pkg::DefSpineBytes,
  parameter int unsigned QUEUE_DEPTH       = iipv_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iipv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [iipv_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    field_kind_o,
  output logic [63:0]                   field_value_o,
  output logic [15:0]                   book_number_o,
  output logic [15:0]                   chapter_number_o,
  output logic                          verdict_valid_o,
  output logic                          image_ok_o,
  output logic [3:0]                    error_code_o
);

  logic [20:0]     max_image_q;
  iipv_pkg::cfg_t  cfg_q;
  logic            push, full, q_valid, pop;
  iipv_pkg::item_t push_item, head_item;

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_image_q     <= iipv_pkg::RstMaxImage;
      cfg_q.max_books <= iipv_pkg::RstMaxBooks;
      cfg_q.max_chaps <= iipv_pkg::RstMaxChaps;
      cfg_q.max_path  <= iipv_pkg::RstMaxPath;
      cfg_q.max_title <= iipv_pkg::RstMaxTitle;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iipv_pkg::CfgMaxImage: max_image_q     <= cfg_data_i;
        iipv_pkg::CfgMaxBooks: cfg_q.max_books <= cfg_data_i[15:0];
        iipv_pkg::CfgMaxChaps: cfg_q.max_chaps <= cfg_data_i[15:0];
        iipv_pkg::CfgMaxPath:  cfg_q.max_path  <= cfg_data_i[15:0];
        iipv_pkg::CfgMaxTitle: cfg_q.max_title <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  iipv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .max_image_i (max_image_q),
    .q_full_i    (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  iipv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  iipv_back #(
    .SPINE_INDEX_BYTES (SPINE_INDEX_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .item_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .field_kind_o     (field_kind_o),
    .field_value_o    (field_value_o),
    .book_number_o    (book_number_o),
    .chapter_number_o (chapter_number_o),
    .verdict_valid_o  (verdict_valid_o),
    .image_ok_o       (image_ok_o),
    .error_code_o     (error_code_o)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for index_image_parse_validate_unit.
// Streams built book index images with random idling and checks every result beat
// against a cycle-free predictor; depends on iipv_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int SpineBytes = iipv_pkg::DefSpineBytes;
  localparam int WatchdogLimit = 4000;
  localparam logic [63:0] MagicText = "A14EPC02";

  typedef struct packed {
    iipv_pkg::kind_e kind;
    logic [63:0]     value;
    logic [15:0]     book;
    logic [15:0]     chap;
    logic            verdict;
    logic            ok;
    iipv_pkg::err_e  code;
  } beat_t;

  // Ways in which a built image departs from a well-formed one.
  typedef enum int {
    M_NONE, M_SHORT, M_MAGIC, M_PLEN, M_CRC, M_BOOKS, M_STRING, M_CHAPS,
    M_TRUNC, M_TRAIL, M_NOISE
  } flaw_e;

  typedef struct {
    flaw_e          flaw;
    iipv_pkg::err_e code;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [iipv_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [iipv_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    data_byte_i;
  logic                          last_byte_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [3:0]                    field_kind_o;
  logic [63:0]                   field_value_o;
  logic [15:0]                   book_number_o;
  logic [15:0]                   chapter_number_o;
  logic                          verdict_valid_o;
  logic                          image_ok_o;
  logic [3:0]                    error_code_o;

  index_image_parse_validate_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .field_kind_o(field_kind_o), .field_value_o(field_value_o),
    .book_number_o(book_number_o), .chapter_number_o(chapter_number_o),
    .verdict_valid_o(verdict_valid_o), .image_ok_o(image_ok_o),
    .error_code_o(error_code_o)
  );

  // Limits as last written to the block.
  logic [20:0] lim_image;
  logic [15:0] lim_books, lim_chaps, lim_path, lim_title;

  // Parser state of the predictor.
  logic [20:0]      p_pos;
  iipv_pkg::phase_e p_phase;
  logic [3:0]       p_fcnt;
  logic [63:0]      p_acc;
  logic [31:0]      p_crc, p_plen, p_scrc;
  logic [15:0]      p_brem, p_book, p_crem, p_chap, p_srem;
  iipv_pkg::err_e   p_err;

  beat_t          pending_beats[$];
  logic [7:0]     pay[$];
  logic [7:0]     img[$];
  iipv_pkg::err_e seen_code;
  int             fails;
  int             idle_cycles;
  int             gap_mode;
  int             stall_mode;
  int             stall_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic int bytes_of(iipv_pkg::phase_e ph);
    case (ph)
      iipv_pkg::PH_PLEN, iipv_pkg::PH_CRC:   return 4;
      iipv_pkg::PH_SIZE, iipv_pkg::PH_MTIME: return 8;
      iipv_pkg::PH_TOC, iipv_pkg::PH_RESUME: return 1;
      iipv_pkg::PH_SPINE:                    return SpineBytes;
      default:                               return 2;
    endcase
  endfunction

  function automatic void clear_stream();
    p_pos = '0;
    p_phase = iipv_pkg::PH_MAGIC;
    p_fcnt = '0;
    p_acc = '0;
    p_crc = 32'hFFFFFFFF;
    p_plen = '0;
    p_scrc = '0;
    p_brem = '0;
    p_book = '0;
    p_crem = '0;
    p_chap = '0;
    p_srem = '0;
    p_err = iipv_pkg::E_NONE;
  endfunction

  function automatic void halt_with(iipv_pkg::err_e c);
    if (p_err == iipv_pkg::E_NONE) p_err = c;
    p_phase = iipv_pkg::PH_HALT;
  endfunction

  function automatic void next_book();
    p_brem = p_brem - 16'd1;
    p_book = p_book + 16'd1;
    if (p_brem == 0) p_phase = iipv_pkg::PH_DONE;
    else begin
      p_chap = '0;
      p_phase = iipv_pkg::PH_PATH_LEN;
    end
  endfunction

  function automatic void open_text(logic [63:0] len, logic [15:0] lim,
                                    iipv_pkg::phase_e chars, iipv_pkg::phase_e after);
    if (len > 64'(lim)) halt_with(iipv_pkg::E_STRING);
    else begin
      p_srem = len[15:0];
      p_phase = (len != 0) ? chars : after;
    end
  endfunction

  // Advances the parser by one byte and returns the beat it must produce.
  function automatic beat_t parse_byte(logic [7:0] b, logic lst);
    beat_t       r;
    logic [63:0] v;
    logic [31:0] len;
    r = '0;
    r.book = p_book;
    r.chap = p_chap;
    if (p_pos >= 21'd16) p_crc = crc_step(p_crc, b);
    case (p_phase)
      iipv_pkg::PH_MAGIC: begin
        if (b != MagicText[63 - 8 * p_fcnt[2:0] -: 8]) halt_with(iipv_pkg::E_MAGIC);
        else begin
          p_fcnt = p_fcnt + 4'd1;
          if (p_fcnt == 4'd8) begin
            p_fcnt = '0;
            p_acc = '0;
            p_phase = iipv_pkg::PH_PLEN;
          end
        end
      end
      iipv_pkg::PH_PATH_CH, iipv_pkg::PH_TITLE_CH, iipv_pkg::PH_CT_CH: begin
        r.kind = (p_phase == iipv_pkg::PH_PATH_CH) ? iipv_pkg::K_PATH_CH :
                 (p_phase == iipv_pkg::PH_TITLE_CH) ? iipv_pkg::K_TITLE_CH :
                                                      iipv_pkg::K_CT_CH;
        r.value = {56'd0, b};
        p_srem = p_srem - 16'd1;
        if (p_srem == 0)
          p_phase = (p_phase == iipv_pkg::PH_PATH_CH) ? iipv_pkg::PH_TITLE_LEN :
                    (p_phase == iipv_pkg::PH_TITLE_CH) ? iipv_pkg::PH_SIZE :
                                                         iipv_pkg::PH_SPINE;
      end
      iipv_pkg::PH_DONE: halt_with(iipv_pkg::E_TRAIL);
      iipv_pkg::PH_HALT: ;
      default: begin
        if (p_fcnt < 4'd8) p_acc = p_acc | ({56'd0, b} << (8 * p_fcnt));
        p_fcnt = p_fcnt + 4'd1;
        if (p_fcnt >= bytes_of(p_phase)) begin
          v = p_acc;
          p_fcnt = '0;
          p_acc = '0;
          case (p_phase)
            iipv_pkg::PH_PLEN: begin
              p_plen = v[31:0];
              p_phase = iipv_pkg::PH_CRC;
            end
            iipv_pkg::PH_CRC: begin
              p_scrc = v[31:0];
              r.kind = iipv_pkg::K_HEADER;
              r.value = {p_scrc, p_plen};
              p_phase = iipv_pkg::PH_BCOUNT;
            end
            iipv_pkg::PH_BCOUNT: begin
              if (v > 64'(lim_books)) halt_with(iipv_pkg::E_BOOKS);
              else begin
                r.kind = iipv_pkg::K_BCOUNT;
                r.value = v;
                p_brem = v[15:0];
                p_book = '0;
                if (v == 0) p_phase = iipv_pkg::PH_DONE;
                else begin
                  p_chap = '0;
                  p_phase = iipv_pkg::PH_PATH_LEN;
                end
              end
            end
            iipv_pkg::PH_PATH_LEN:
              open_text(v, lim_path, iipv_pkg::PH_PATH_CH, iipv_pkg::PH_TITLE_LEN);
            iipv_pkg::PH_TITLE_LEN:
              open_text(v, lim_title, iipv_pkg::PH_TITLE_CH, iipv_pkg::PH_SIZE);
            iipv_pkg::PH_CT_LEN:
              open_text(v, lim_title, iipv_pkg::PH_CT_CH, iipv_pkg::PH_SPINE);
            iipv_pkg::PH_SIZE: begin
              r.kind = iipv_pkg::K_SIZE; r.value = v; p_phase = iipv_pkg::PH_MTIME;
            end
            iipv_pkg::PH_MTIME: begin
              r.kind = iipv_pkg::K_MTIME; r.value = v; p_phase = iipv_pkg::PH_TOC;
            end
            iipv_pkg::PH_TOC: begin
              r.kind = iipv_pkg::K_TOC; r.value = v; p_phase = iipv_pkg::PH_RESUME;
            end
            iipv_pkg::PH_RESUME: begin
              r.kind = iipv_pkg::K_RESUME; r.value = v; p_phase = iipv_pkg::PH_SECTION;
            end
            iipv_pkg::PH_SECTION: begin
              r.kind = iipv_pkg::K_SECTION; r.value = v; p_phase = iipv_pkg::PH_PAGE;
            end
            iipv_pkg::PH_PAGE: begin
              r.kind = iipv_pkg::K_PAGE; r.value = v; p_phase = iipv_pkg::PH_CCOUNT;
            end
            iipv_pkg::PH_CCOUNT: begin
              if (v > 64'(lim_chaps)) halt_with(iipv_pkg::E_CHAPS);
              else begin
                r.kind = iipv_pkg::K_CCOUNT;
                r.value = v;
                p_crem = v[15:0];
                p_chap = '0;
                if (v == 0) next_book();
                else p_phase = iipv_pkg::PH_CT_LEN;
              end
            end
            iipv_pkg::PH_SPINE: begin
              r.kind = iipv_pkg::K_SPINE;
              r.value = v;
              p_crem = p_crem - 16'd1;
              p_chap = p_chap + 16'd1;
              if (p_crem == 0) next_book();
              else p_phase = iipv_pkg::PH_CT_LEN;
            end
            default: ;
          endcase
        end
      end
    endcase

    if (lst) begin
      len = 32'(p_pos) + 32'd1;
      r.verdict = 1'b1;
      if (len < 32'd16 || len > 32'(lim_image)) r.code = iipv_pkg::E_LENGTH;
      else if (p_err == iipv_pkg::E_MAGIC) r.code = iipv_pkg::E_MAGIC;
      else if (p_plen != len - 32'd16) r.code = iipv_pkg::E_PSIZE;
      else if (~p_crc != p_scrc) r.code = iipv_pkg::E_CRC;
      else if (p_err != iipv_pkg::E_NONE) r.code = p_err;
      else if (p_phase != iipv_pkg::PH_DONE) r.code = iipv_pkg::E_TRUNC;
      else r.code = iipv_pkg::E_NONE;
      r.ok = (r.code == iipv_pkg::E_NONE);
      clear_stream();
    end else if (p_pos != '1) begin
      p_pos = p_pos + 21'd1;
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fails++;
    if (fails <= 10) $display("%s: expected %0h, got %0h", what, want, got);
  endfunction

  // Image construction helpers; the payload goes to pay, the whole image to img.
  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) pay = {pay, v[8 * i +: 8]};
  endfunction

  function automatic void put_junk();
    repeat ($urandom_range(0, 3)) pay = {pay, 8'($urandom)};
  endfunction

  function automatic void put_text(logic [15:0] lim);
    int n;
    n = $urandom_range(0, (lim < 3) ? lim : 3);
    put_le(64'(n), 2);
    repeat (n) pay = {pay, 8'($urandom)};
  endfunction

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void make_payload(flaw_e f);
    int nb, nc;
    if (f == M_BOOKS) begin
      put_le(64'(lim_books) + 64'd1, 2);
      put_junk();
      return;
    end
    nb = $urandom_range(0, (lim_books < 2) ? lim_books : 2);
    if ((f == M_STRING || f == M_CHAPS) && nb == 0) nb = 1;
    put_le(64'(nb), 2);
    for (int bk = 0; bk < nb; bk++) begin
      if (f == M_STRING && bk == 0) begin
        put_le(64'(lim_path) + 64'd1, 2);
        put_junk();
        return;
      end
      put_text(lim_path);
      put_text(lim_title);
      put_le(pick_wide(), 8);
      put_le(pick_wide(), 8);
      put_le(64'($urandom), 1);
      put_le(64'($urandom), 1);
      put_le(64'($urandom), 2);
      put_le(64'($urandom), 2);
      if (f == M_CHAPS && bk == 0) begin
        put_le(64'(lim_chaps) + 64'd1, 2);
        put_junk();
        return;
      end
      nc = $urandom_range(0, (lim_chaps < 2) ? lim_chaps : 2);
      put_le(64'(nc), 2);
      for (int c = 0; c < nc; c++) begin
        put_text(lim_title);
        put_le(64'($urandom), SpineBytes);
      end
    end
  endfunction

  function automatic void make_image(flaw_e f);
    logic [31:0] crc, plen;
    int          n;
    img.delete();
    pay.delete();
    // Fall back to a clean image where the limits leave no room for the flaw.
    if (f == M_BOOKS && lim_books == 16'hFFFF) f = M_NONE;
    if ((f == M_STRING || f == M_CHAPS) && lim_books == 0) f = M_NONE;
    if (f == M_STRING && lim_path == 16'hFFFF) f = M_NONE;
    if (f == M_CHAPS && lim_chaps == 16'hFFFF) f = M_NONE;
    if (f == M_SHORT || f == M_NOISE) begin
      repeat ($urandom_range(1, (f == M_SHORT) ? 15 : 40)) img = {img, 8'($urandom)};
      return;
    end
    make_payload(f);
    if (f == M_TRUNC && pay.size() > 0) begin
      n = $urandom_range(1, (pay.size() < 6) ? pay.size() : 6);
      repeat (n) void'(pay.pop_back());
    end
    if (f == M_TRAIL) repeat ($urandom_range(1, 3)) pay = {pay, 8'($urandom)};
    crc = 32'hFFFFFFFF;
    foreach (pay[i]) crc = crc_step(crc, pay[i]);
    crc = ~crc;
    plen = 32'(pay.size());
    if (f == M_PLEN) plen = plen + $urandom_range(1, 3);
    if (f == M_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 8; i++) img = {img, MagicText[63 - 8 * i -: 8]};
    if (f == M_MAGIC) begin
      n = $urandom_range(0, 7);
      img[n] = img[n] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < 4; i++) img = {img, plen[8 * i +: 8]};
    for (int i = 0; i < 4; i++) img = {img, crc[8 * i +: 8]};
    foreach (pay[i]) img = {img, pay[i]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Sends one beat; valid stays high into the next call unless a gap follows.
  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every expected beat has come and the pipeline has settled.
  task automatic wait_idle();
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [iipv_pkg::CfgIdxW-1:0] idx, logic [20:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      iipv_pkg::CfgMaxImage: lim_image = val;
      iipv_pkg::CfgMaxBooks: lim_books = val[15:0];
      iipv_pkg::CfgMaxChaps: lim_chaps = val[15:0];
      iipv_pkg::CfgMaxPath:  lim_path = val[15:0];
      iipv_pkg::CfgMaxTitle: lim_title = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [20:0] im, logic [15:0] bk, logic [15:0] ch,
                            logic [15:0] pa, logic [15:0] ti);
    write_reg(iipv_pkg::CfgMaxImage, im);
    write_reg(iipv_pkg::CfgMaxBooks, 21'(bk));
    write_reg(iipv_pkg::CfgMaxChaps, 21'(ch));
    write_reg(iipv_pkg::CfgMaxPath, 21'(pa));
    write_reg(iipv_pkg::CfgMaxTitle, 21'(ti));
  endtask

  // Result stall: random bursts, mostly short, sometimes long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (stall_mode != 0 && $urandom_range(0, 99) < ((stall_mode == 2) ? 35 : 10))
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                 : $urandom_range(1, 3);
    end
  end

  // Checks result beats, predicts accepted input beats and guards against hangs.
  always @(posedge clk_i) begin : monitor
    beat_t got, want;
    logic  moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got.kind = iipv_pkg::kind_e'(field_kind_o);
        got.value = field_value_o;
        got.book = book_number_o;
        got.chap = chapter_number_o;
        got.verdict = verdict_valid_o;
        got.ok = image_ok_o;
        got.code = iipv_pkg::err_e'(error_code_o);
        if (verdict_valid_o) seen_code = got.code;
        if (pending_beats.size() == 0) note_mismatch("beat with nothing pending", '0, got.value);
        else begin
          want = pending_beats.pop_front();
          if (got.kind != want.kind) note_mismatch("field_kind", want.kind, got.kind);
          if (got.value != want.value) note_mismatch("field_value", want.value, got.value);
          if (got.book != want.book) note_mismatch("book_number", want.book, got.book);
          if (got.chap != want.chap) note_mismatch("chapter_number", want.chap, got.chap);
          if (got.verdict != want.verdict)
            note_mismatch("verdict_valid", want.verdict, got.verdict);
          if (got.ok != want.ok) note_mismatch("image_ok", want.ok, got.ok);
          if (got.code != want.code) note_mismatch("error_code", want.code, got.code);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        want = parse_byte(data_byte_i, last_byte_i);
        pending_beats = {pending_beats, want};
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Directed images under reset limits, each with the verdict it must end in.
  dir_row_t dir_rows[11] = '{
    '{M_NONE, iipv_pkg::E_NONE}, '{M_SHORT, iipv_pkg::E_LENGTH},
    '{M_MAGIC, iipv_pkg::E_MAGIC}, '{M_PLEN, iipv_pkg::E_PSIZE},
    '{M_CRC, iipv_pkg::E_CRC}, '{M_BOOKS, iipv_pkg::E_BOOKS},
    '{M_STRING, iipv_pkg::E_STRING}, '{M_CHAPS, iipv_pkg::E_CHAPS},
    '{M_TRUNC, iipv_pkg::E_TRUNC}, '{M_TRAIL, iipv_pkg::E_TRAIL},
    '{M_NONE, iipv_pkg::E_NONE}
  };

  initial begin : stimulus
    int    total_bytes, round;
    flaw_e f;
    total_bytes = 0;
    round = 0;
    fails = 0;
    idle_cycles = 0;
    gap_mode = 0;
    stall_mode = 0;
    seen_code = iipv_pkg::E_NONE;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    lim_image = iipv_pkg::RstMaxImage;
    lim_books = iipv_pkg::RstMaxBooks;
    lim_chaps = iipv_pkg::RstMaxChaps;
    lim_path = iipv_pkg::RstMaxPath;
    lim_title = iipv_pkg::RstMaxTitle;
    clear_stream();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      gap_mode = i % 2;
      stall_mode = i % 3;
      make_image(dir_rows[i].flaw);
      total_bytes += img.size();
      send_image();
      wait_idle();
      if (seen_code != dir_rows[i].code) note_mismatch("directed verdict",
                                                       dir_rows[i].code, seen_code);
    end

    // Random images, each under the next limit setting, extremes included.
    while (round < 4 || total_bytes < 400) begin
      case (round % 4)
        0: set_limits(21'd16, 16'd0, 16'd0, 16'd0, 16'd0);
        1: set_limits(21'd1048576, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_limits(21'($urandom_range(16, 200)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
                      16'($urandom_range(0, 4)));
        default: set_limits(iipv_pkg::RstMaxImage, iipv_pkg::RstMaxBooks,
                            iipv_pkg::RstMaxChaps, iipv_pkg::RstMaxPath,
                            iipv_pkg::RstMaxTitle);
      endcase
      gap_mode = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 2);
      f = ($urandom_range(0, 99) < 55) ? M_NONE : flaw_e'($urandom_range(1, 10));
      make_image(f);
      total_bytes += img.size();
      send_image();
      round++;
    end

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
